// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Each macro wraps one clocked concurrent assertion with an async low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/h2r_pkg.sv =====
// Package for the HSV to RGB converter: widths, fixed-point constants,
// sector codes and the pipeline control struct. No dependencies.
`default_nettype none

package h2r_pkg;

  localparam int HUE_W      = 15;
  localparam int CH_W       = 8;
  localparam int FRAC_W     = 12;
  localparam int SEC_SHIFT  = 8;   // 3840 = 15 << 8
  localparam int SEC_STEP   = 15;
  localparam int SEC_COUNT  = 6;
  localparam int HUE_HI_W   = HUE_W - SEC_SHIFT;
  localparam int STEP_W     = 4;

  localparam int SECTOR_UNITS_I = SEC_STEP << SEC_SHIFT;
  localparam int RAW_MAX        = ((1 << HUE_W) - 1) / SECTOR_UNITS_I;
  localparam int RAW_W          = 4;
  localparam int FULL_SCALE_I   = 255;

  localparam int DENOM_W  = 20;
  localparam int NUM_W    = DENOM_W + CH_W;
  localparam int Y_W      = NUM_W - SEC_SHIFT;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SHIFT = 32;
  localparam int Z_W      = Y_W + RECIP_W;

  localparam logic [FRAC_W-1:0]  SECTOR_UNITS = FRAC_W'(SECTOR_UNITS_I);
  localparam logic [DENOM_W-1:0] DENOM      = DENOM_W'(FULL_SCALE_I * SECTOR_UNITS_I);
  localparam logic [NUM_W-1:0]   HALF_DENOM = NUM_W'((FULL_SCALE_I * SECTOR_UNITS_I) / 2);
  // ceil(2^32 / 3825): exact quotient for any dividend below 2^20
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(1122868);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } h2r_sector_e;

  typedef struct packed {
    logic en_s1;
    logic en_s2;
    logic en_s3;
    logic en_s4;
  } h2r_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/h2r_if.sv =====
// Stream interfaces for HSV input pixels and RGB output pixels.
// Depends on h2r_pkg for field widths.
`default_nettype none

interface h2r_hsv_if import h2r_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;

  modport source(output valid, hue, saturation, brightness, input ready);
  modport sink(input valid, hue, saturation, brightness, output ready);
endinterface

interface h2r_rgb_if import h2r_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/h2r_split.sv =====
// Stage 1: splits hue into sector and remainder over 3840, registers s and v.
// Depends on h2r_pkg.
`default_nettype none

module h2r_split import h2r_pkg::*; (
  input  logic               clk_i,
  input  h2r_ctl_t           ctl_i,
  input  logic [HUE_W-1:0]   hue_i,
  input  logic [CH_W-1:0]    sat_i,
  input  logic [CH_W-1:0]    val_i,
  output h2r_sector_e        sector_o,
  output logic [FRAC_W-1:0]  rem_o,
  output logic [CH_W-1:0]    sat_o,
  output logic [CH_W-1:0]    val_o
);

  logic [HUE_HI_W-1:0] hue_hi;
  logic [RAW_W-1:0]    raw;
  logic [STEP_W-1:0]   rem_hi;
  h2r_sector_e         sector_d, sector_q;
  logic [FRAC_W-1:0]   rem_d, rem_q;
  logic [CH_W-1:0]     sat_q, val_q;

  assign hue_hi = hue_i[HUE_W-1:SEC_SHIFT];

  // hue / 3840 == (hue >> 8) / 15: count the multiples of 15 passed
  always_comb begin
    raw = '0;
    for (int k = 1; k <= RAW_MAX; k++) begin
      if (hue_hi >= HUE_HI_W'(SEC_STEP * k)) begin
        raw = raw + RAW_W'(1);
      end
    end
  end

  always_comb begin
    rem_hi = STEP_W'(hue_hi - HUE_HI_W'(raw) * HUE_HI_W'(SEC_STEP));
    rem_d  = {rem_hi, hue_i[SEC_SHIFT-1:0]};
    // wrap out-of-range sectors back into 0..5
    if (raw >= RAW_W'(SEC_COUNT)) begin
      sector_d = h2r_sector_e'(3'(raw - RAW_W'(SEC_COUNT)));
    end else begin
      sector_d = h2r_sector_e'(3'(raw));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_s1) begin
      sector_q <= sector_d;
      rem_q    <= rem_d;
      sat_q    <= sat_i;
      val_q    <= val_i;
    end
  end

  assign sector_o = sector_q;
  assign rem_o    = rem_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;

endmodule

`default_nettype wire

// ===== hdl/h2r_scale.sv =====
// Stages 2 to 4: rounds v * (1 - frac * s) to an 8-bit level.
// Depends on h2r_pkg. Division by 979200 is a reciprocal multiply.
`default_nettype none

module h2r_scale import h2r_pkg::*; (
  input  logic               clk_i,
  input  h2r_ctl_t           ctl_i,
  input  logic [FRAC_W-1:0]  frac_i,
  input  logic [CH_W-1:0]    sat_i,
  input  logic [CH_W-1:0]    val_i,
  output logic [CH_W-1:0]    level_o
);

  logic [DENOM_W-1:0] diff_d, diff_q;
  logic [CH_W-1:0]    val_q;
  logic [NUM_W-1:0]   num;
  logic [Y_W-1:0]     y_d, y_q;
  logic [Z_W-1:0]     z;
  logic [CH_W-1:0]    level_d, level_q;

  // frac * s never exceeds 255 * 3840, so the difference never goes negative
  assign diff_d = DENOM - DENOM_W'(frac_i) * DENOM_W'(sat_i);

  assign num = NUM_W'(val_q) * NUM_W'(diff_q) + HALF_DENOM;
  // 979200 = 256 * 3825: drop the power of two here
  assign y_d = num[NUM_W-1:SEC_SHIFT];

  assign z       = Z_W'(y_q) * Z_W'(RECIP);
  assign level_d = z[RECIP_SHIFT +: CH_W];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_s2) begin
      diff_q <= diff_d;
      val_q  <= val_i;
    end
    if (ctl_i.en_s3) begin
      y_q <= y_d;
    end
    if (ctl_i.en_s4) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_pixel_converter.sv =====
// Top level of the HSV to RGB converter: pipeline control, sector routing.
// Depends on h2r_pkg, h2r_if, h2r_split, h2r_scale and assert_macros.svh.
//
//   channel   modport   fields                          per transfer
//   hsv_i     sink      hue, saturation, brightness      one pixel in
//   rgb_o     source    red, green, blue                 one pixel out
//
// One pixel per clock while rgb_o is not stalled; five register stages
// (split, product, scale, reciprocal multiply, routing register) lie
// between the input transfer and output valid.
// rst_ni clears only the valid bits; payload registers are not reset.
// A stall on rgb_o fills the empty stages first, then drops hsv_i.ready.
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_pixel_converter import h2r_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  h2r_hsv_if.sink     hsv_i,
  h2r_rgb_if.source   rgb_o
);

  h2r_ctl_t          ctl;
  logic              en_out;
  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;

  h2r_sector_e       sec1, sec2_q, sec3_q, sec4_q;
  logic [FRAC_W-1:0] rem1, frac_t;
  logic [CH_W-1:0]   sat1, val1;
  logic [CH_W-1:0]   p_lvl, q_lvl, t_lvl;
  logic [CH_W-1:0]   val2_q, val3_q, val4_q;
  logic [CH_W-1:0]   red_d, green_d, blue_d;
  logic [CH_W-1:0]   red_q, green_q, blue_q;

  // a stage advances when it is empty or the one after it advances
  assign en_out    = !out_vld_q || rgb_o.ready;
  assign ctl.en_s4 = !s4_vld_q || en_out;
  assign ctl.en_s3 = !s3_vld_q || ctl.en_s4;
  assign ctl.en_s2 = !s2_vld_q || ctl.en_s3;
  assign ctl.en_s1 = !s1_vld_q || ctl.en_s2;
  assign hsv_i.ready = ctl.en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (ctl.en_s1) s1_vld_q  <= hsv_i.valid;
      if (ctl.en_s2) s2_vld_q  <= s1_vld_q;
      if (ctl.en_s3) s3_vld_q  <= s2_vld_q;
      if (ctl.en_s4) s4_vld_q  <= s3_vld_q;
      if (en_out)    out_vld_q <= s4_vld_q;
    end
  end

  h2r_split u_split (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .hue_i    (hsv_i.hue),
    .sat_i    (hsv_i.saturation),
    .val_i    (hsv_i.brightness),
    .sector_o (sec1),
    .rem_o    (rem1),
    .sat_o    (sat1),
    .val_o    (val1)
  );

  assign frac_t = SECTOR_UNITS - rem1;

  h2r_scale u_scale_p (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .frac_i  (SECTOR_UNITS),
    .sat_i   (sat1),
    .val_i   (val1),
    .level_o (p_lvl)
  );

  h2r_scale u_scale_q (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .frac_i  (rem1),
    .sat_i   (sat1),
    .val_i   (val1),
    .level_o (q_lvl)
  );

  h2r_scale u_scale_t (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .frac_i  (frac_t),
    .sat_i   (sat1),
    .val_i   (val1),
    .level_o (t_lvl)
  );

  // carry sector and v alongside the scale stages
  always_ff @(posedge clk_i) begin
    if (ctl.en_s2) begin
      sec2_q <= sec1;
      val2_q <= val1;
    end
    if (ctl.en_s3) begin
      sec3_q <= sec2_q;
      val3_q <= val2_q;
    end
    if (ctl.en_s4) begin
      sec4_q <= sec3_q;
      val4_q <= val3_q;
    end
  end

  always_comb begin
    unique case (sec4_q)
      SEC_RY: begin
        red_d = val4_q; green_d = t_lvl;  blue_d = p_lvl;
      end
      SEC_YG: begin
        red_d = q_lvl;  green_d = val4_q; blue_d = p_lvl;
      end
      SEC_GC: begin
        red_d = p_lvl;  green_d = val4_q; blue_d = t_lvl;
      end
      SEC_CB: begin
        red_d = p_lvl;  green_d = q_lvl;  blue_d = val4_q;
      end
      SEC_BM: begin
        red_d = t_lvl;  green_d = p_lvl;  blue_d = val4_q;
      end
      default: begin
        red_d = val4_q; green_d = p_lvl;  blue_d = q_lvl;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = out_vld_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

  `ASSERT_IMPL(a_ready_low_full, clk_i, rst_ni, !hsv_i.ready,
    s1_vld_q && s2_vld_q && s3_vld_q && s4_vld_q && out_vld_q && !rgb_o.ready,
    "input blocked while pipeline has room")
  `ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, hsv_i.valid && hsv_i.ready,
    s1_vld_q, "accepted pixel missing from stage 1")
  `ASSERT_NEXT(a_s4_holds, clk_i, rst_ni, s4_vld_q && !ctl.en_s4,
    s4_vld_q, "stalled stage 4 pixel lost")
  `ASSERT_IMPL(a_out_from_s4, clk_i, rst_ni, $rose(out_vld_q),
    $past(s4_vld_q), "output valid without stage 4 pixel")

endmodule

`default_nettype wire
